/* sv/klsr_pkg.sv */
// klsr_pkg: shared types, command codes and default sizes for the keymap
// layer stack resolver; no dependencies, imported by every module of the block
package klsr_pkg;

   // default table sizes
   localparam int ROWS_DEF   = 8;
   localparam int COLS_DEF   = 16;
   localparam int KEYS_DEF   = 128;
   localparam int LAYERS_DEF = 16;

   // fixed field widths
   localparam int MASK_BITS  = 16;
   localparam int LAYER_W    = 4;
   localparam int CODE_W     = 32;
   localparam int CMD_W      = 3;
   localparam int ROW_W      = 3;
   localparam int COL_W      = 4;
   localparam int KIDX_W     = 8;
   localparam int LIU_W      = 5;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_SET_MASK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LAYER_ON  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LAYER_OFF = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TOGGLE    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESOLVE   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd5;
   localparam logic [CMD_W-1:0] CMD_WR_KEYMAP = 3'd6;
   localparam logic [CMD_W-1:0] CMD_WR_LAYOUT = 3'd7;

   // configuration register indexes
   localparam logic CSR_LAYERS_IN_USE = 1'b0;
   localparam logic CSR_TRANSPARENT   = 1'b1;

   // reset values
   localparam logic [LIU_W-1:0]     LIU_RESET   = 5'd16;
   localparam logic [CODE_W-1:0]    TRANS_RESET = 32'd1;
   localparam logic [MASK_BITS-1:0] MASK_RESET  = 16'd1;
   localparam logic [KIDX_W-1:0]    UNMAPPED    = 8'hFF;

   // layer stack state after a mask command
   typedef struct packed {
      logic [MASK_BITS-1:0] mask;
      logic [LAYER_W-1:0]   top;
   } klsr_mask_type;

endpackage

/* sv/klsr_mask_unit.sv */
// klsr_mask_unit: applies a set/on/off/toggle command to the layer mask,
// falls back to the base layer on an empty mask and finds the top layer
// depends on klsr_pkg
module klsr_mask_unit
   import klsr_pkg::*;
(
   input  logic [CMD_W-1:0]     command,
   input  logic [LAYER_W-1:0]   layer_index,
   input  logic [MASK_BITS-1:0] state_mask,
   input  logic [MASK_BITS-1:0] mask_cur,
   output klsr_mask_type        result
);

   logic [MASK_BITS-1:0] bit_sel;
   logic [MASK_BITS-1:0] raw;
   logic [MASK_BITS-1:0] fixed;
   logic [LAYER_W-1:0]   top;

   assign bit_sel = MASK_BITS'(1) << layer_index;

   always_comb begin
      unique case (command)
         CMD_SET_MASK:  raw = state_mask;
         CMD_LAYER_ON:  raw = mask_cur | bit_sel;
         CMD_LAYER_OFF: raw = mask_cur & ~bit_sel;
         CMD_TOGGLE:    raw = mask_cur ^ bit_sel;
         default:       raw = mask_cur;
      endcase
   end

   assign fixed = (raw == '0) ? MASK_RESET : raw;

   // highest set bit wins
   always_comb begin
      top = '0;
      for (int i = 0; i < MASK_BITS; i++) begin
         if (fixed[i]) begin
            top = LAYER_W'(i);
         end
      end
   end

   assign result.mask = fixed;
   assign result.top  = top;

endmodule

/* sv/keymap_layer_stack_resolver_top.sv */
// keymap_layer_stack_resolver_top: layer mask, layout table and per-layer
// keycode table with a layer-by-layer resolve sequencer
// depends on klsr_pkg and klsr_mask_unit
//
//  channel  direction  handshake               payload
//  req_     in         req_tvalid/req_tready   tuser command, tdata fields
//  rsp_     out        rsp_tvalid/rsp_tready   tdata result fields
//  csr_     in         csr_valid/csr_ready     csr_index, csr_data
//
// mask and table write commands go from idle straight to done; a lookup reads
// the layout, then its one layer; a resolve scans down from the top layer: one
// keymap memory read per enabled layer, shared by the scan, with the compare
// overlapped with the next read; after reset the layout table is swept to
// unmapped with req_tready low; csr writes are taken throughout
// one request at a time; a finished result sits in the output register
// and stalls only the return to idle while rsp_tready is low
module keymap_layer_stack_resolver_top
   import klsr_pkg::*;
#(
   parameter int ROWS   = ROWS_DEF,
   parameter int COLS   = COLS_DEF,
   parameter int KEYS   = KEYS_DEF,
   parameter int LAYERS = LAYERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // command
   // layer_index[3:0], state_mask[19:4], row[22:20], col[26:23],
   // key_index[34:27], keycode_in[66:35], zero fill [71:67]
   input  logic [71:0] req_tdata,
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // keycode[31:0], active_layer[35:32], layer_mask[51:36],
   // layer_changed[52], zero fill [55:53]
   output logic [55:0] rsp_tdata,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int LO_DEPTH = ROWS * COLS;
   localparam int LO_AW    = (LO_DEPTH > 1) ? $clog2(LO_DEPTH) : 1;
   localparam int KM_DEPTH = LAYERS * KEYS;
   localparam int KM_AW    = (KM_DEPTH > 1) ? $clog2(KM_DEPTH) : 1;

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_LKUP  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   // request fields
   logic [CMD_W-1:0]     f_cmd;
   logic [LAYER_W-1:0]   f_layer;
   logic [MASK_BITS-1:0] f_smask;
   logic [ROW_W-1:0]     f_row;
   logic [COL_W-1:0]     f_col;
   logic [KIDX_W-1:0]    f_kidx;
   logic [CODE_W-1:0]    f_kcode;

   assign f_cmd   = req_tuser;
   assign f_layer = req_tdata[3:0];
   assign f_smask = req_tdata[19:4];
   assign f_row   = req_tdata[22:20];
   assign f_col   = req_tdata[26:23];
   assign f_kidx  = req_tdata[34:27];
   assign f_kcode = req_tdata[66:35];

   // control state
   logic [2:0]           state_ff, state_in;
   logic [LO_AW-1:0]     clr_ff, clr_in;
   logic [MASK_BITS-1:0] mask_ff, mask_in;
   logic [LAYER_W-1:0]   top_ff, top_in;
   logic [LIU_W-1:0]     liu_ff;
   logic [CODE_W-1:0]    trans_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic                 done_ff, done_in;

   // working registers
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [LAYER_W-1:0]   li_ff, li_in;
   logic                 pos_ok_ff, pos_ok_in;
   logic [LAYER_W-1:0]   lay_ff, lay_in;
   logic [KIDX_W-2:0]    key_ff, key_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic                 chg_ff, chg_in;

   // result register
   logic [CODE_W-1:0]    out_code_ff;
   logic [LAYER_W-1:0]   out_top_ff;
   logic [MASK_BITS-1:0] out_mask_ff;
   logic                 out_chg_ff;
   logic                 out_load;

   // memories
   logic [KIDX_W-1:0]    lo_mem [LO_DEPTH];
   logic [KIDX_W-1:0]    lo_rd_ff;
   logic [CODE_W-1:0]    km_mem [KM_DEPTH];
   logic [CODE_W-1:0]    km_rd_ff;

   logic                 accept;
   logic                 pos_ok;
   logic [LO_AW-1:0]     lo_addr;
   logic                 lo_we;
   logic [LO_AW-1:0]     lo_waddr;
   logic [KIDX_W-1:0]    lo_wdata;
   logic                 lo_re;
   logic                 km_we;
   logic [KM_AW-1:0]     km_waddr;
   logic                 km_re;
   logic [KM_AW-1:0]     km_raddr;
   logic                 key_ok;
   logic                 lay_en;
   logic                 hit;
   klsr_mask_type        mres;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   // matrix position inside the table
   assign pos_ok  = ({3'b000, f_row} < 6'(ROWS)) && ({2'b00, f_col} < 6'(COLS));
   assign lo_addr = LO_AW'(int'(f_row) * COLS + int'(f_col));

   klsr_mask_unit u_mask (
      .command     (f_cmd),
      .layer_index (f_layer),
      .state_mask  (f_smask),
      .mask_cur    (mask_ff),
      .result      (mres)
   );

   // stored flat index is usable when non-negative and below KEYS
   assign key_ok = !lo_rd_ff[KIDX_W-1] && ({4'b0000, lo_rd_ff[KIDX_W-2:0]} < 11'(KEYS));

   // layer takes part when present and in use; a resolve also needs it active
   assign lay_en = (mask_ff[lay_ff] || (cmd_ff == CMD_LOOKUP))
                   && ({1'b0, lay_ff} < 5'(LAYERS)) && ({1'b0, lay_ff} < liu_ff);

   assign hit = chk_vld_ff && (km_rd_ff != '0) && (km_rd_ff != trans_ff);

   assign km_raddr = KM_AW'(int'(lay_ff) * KEYS + int'(key_ff));
   assign km_waddr = KM_AW'(int'(f_layer) * KEYS + int'(f_kidx));

   assign out_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // layout write port: clearing sweep or layout write command
   always_comb begin
      lo_we    = 1'b0;
      lo_waddr = lo_addr;
      lo_wdata = f_kidx;
      if (state_ff == S_CLEAR) begin
         lo_we    = 1'b1;
         lo_waddr = clr_ff;
         lo_wdata = UNMAPPED;
      end else if (accept && (f_cmd == CMD_WR_LAYOUT) && pos_ok) begin
         lo_we = 1'b1;
      end
   end

   assign lo_re = accept && pos_ok;
   assign km_we = accept && (f_cmd == CMD_WR_KEYMAP) && ({1'b0, f_layer} < 5'(LAYERS))
                  && !f_kidx[KIDX_W-1] && ({3'b000, f_kidx} < 11'(KEYS));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      mask_in      = mask_ff;
      top_in       = top_ff;
      chk_vld_in   = chk_vld_ff;
      done_in      = done_ff;
      cmd_in       = cmd_ff;
      li_in        = li_ff;
      pos_ok_in    = pos_ok_ff;
      lay_in       = lay_ff;
      key_in       = key_ff;
      code_in      = code_ff;
      chg_in       = chg_ff;
      km_re        = 1'b0;
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + LO_AW'(1);
            if (clr_ff == LO_AW'(LO_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in    = f_cmd;
               li_in     = f_layer;
               pos_ok_in = pos_ok;
               code_in   = '0;
               chg_in    = 1'b0;
               unique case (f_cmd)
                  CMD_SET_MASK, CMD_LAYER_ON, CMD_LAYER_OFF, CMD_TOGGLE: begin
                     mask_in  = mres.mask;
                     top_in   = mres.top;
                     chg_in   = 1'b1;
                     state_in = S_DONE;
                  end
                  CMD_RESOLVE, CMD_LOOKUP: begin
                     state_in = S_LKUP;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_LKUP: begin
            // layout entry is in lo_rd_ff now
            key_in     = lo_rd_ff[KIDX_W-2:0];
            chk_vld_in = 1'b0;
            done_in    = 1'b0;
            lay_in     = (cmd_ff == CMD_RESOLVE) ? top_ff : li_ff;
            if (pos_ok_ff && key_ok) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (cmd_ff == CMD_LOOKUP) begin
               if (done_ff) begin
                  code_in  = chk_vld_ff ? km_rd_ff : '0;
                  state_in = S_DONE;
               end else begin
                  km_re      = lay_en;
                  chk_vld_in = lay_en;
                  done_in    = 1'b1;
               end
            end else if (hit) begin
               code_in  = km_rd_ff;
               state_in = S_DONE;
            end else if (done_ff) begin
               state_in = S_DONE;
            end else begin
               // read this layer while checking the one above
               km_re      = lay_en;
               chk_vld_in = lay_en;
               done_in    = (lay_ff == '0);
               lay_in     = lay_ff - LAYER_W'(1);
            end
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         mask_ff      <= MASK_RESET;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         mask_ff      <= mask_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         done_ff      <= done_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         liu_ff   <= LIU_RESET;
         trans_ff <= TRANS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LAYERS_IN_USE: liu_ff   <= csr_data[LIU_W-1:0];
            CSR_TRANSPARENT:   trans_ff <= csr_data;
            default:           liu_ff   <= liu_ff;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      li_ff     <= li_in;
      pos_ok_ff <= pos_ok_in;
      lay_ff    <= lay_in;
      key_ff    <= key_in;
      code_ff   <= code_in;
      chg_ff    <= chg_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_code_ff <= code_ff;
         out_top_ff  <= top_ff;
         out_mask_ff <= mask_ff;
         out_chg_ff  <= chg_ff;
      end
   end

   // layout table
   always_ff @(posedge clock) begin
      if (lo_we) begin
         lo_mem[lo_waddr] <= lo_wdata;
      end
      if (lo_re) begin
         lo_rd_ff <= lo_mem[lo_addr];
      end
   end

   // keycode table, layer-major
   always_ff @(posedge clock) begin
      if (km_we) begin
         km_mem[km_waddr] <= f_kcode;
      end
      if (km_re) begin
         km_rd_ff <= km_mem[km_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, out_chg_ff, out_mask_ff, out_top_ff, out_code_ff};

endmodule

/* tb/sv/tb_top.sv */
// tb_top: self-checking testbench for keymap_layer_stack_resolver_top
// drives mask, resolve, lookup and table write requests and checks every response
// against a layer stack predictor or a hand-typed value; depends on klsr_pkg and the block's rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import klsr_pkg::*;

   // run shape
   localparam int STALL_LIMIT   = 4000;  // cycles with no handshake before giving up
   localparam int SETTLE_CYCLES = 24;    // longest resolve plus margin
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 55;
   localparam int HOLD_CYCLES   = 400;   // long response back-pressure stretch
   localparam int POOL_KEYS     = 16;    // keys the layout may point at

   // one request as the block sees it
   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [LAYER_W-1:0]   layer;
      logic [MASK_BITS-1:0] mask;
      logic [ROW_W-1:0]     row;
      logic [COL_W-1:0]     col;
      logic [KIDX_W-1:0]    key;
      logic [CODE_W-1:0]    code_in;
   } layer_req_type;

   // one response
   typedef struct packed {
      logic [CODE_W-1:0]    keycode;
      logic [LAYER_W-1:0]   active;
      logic [MASK_BITS-1:0] mask;
      logic                 changed;
   } layer_rsp_type;

   // directed stimulus row, with an optional hand-typed response
   typedef struct {
      layer_req_type req;
      bit            typed;
      layer_rsp_type want;
   } directed_row_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // block ports, all inputs known from time zero
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser  = '0;
   logic [71:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [31:0] csr_data   = '0;

   keymap_layer_stack_resolver_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor state: the layer stack, both tables and the two registers
   logic [MASK_BITS-1:0] mask_model;
   logic [LAYER_W-1:0]   top_model;
   logic [LIU_W-1:0]     liu_model;
   logic [CODE_W-1:0]    trans_model;
   logic [KIDX_W-1:0]    layout_model [ROWS_DEF*COLS_DEF];
   logic [CODE_W-1:0]    keymap_model [LAYERS_DEF*KEYS_DEF];

   // responses still owed by the block, oldest first
   layer_rsp_type expected_results [$];
   directed_row_type directed_rows [$];

   // idle rates in percent, changed per phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // long hold-off requests, served by the response process
   int hold_requests = 0;

   // bookkeeping
   int failures          = 0;
   int requests_sent     = 0;
   int responses_checked = 0;
   int resolve_hits      = 0;
   int settings_run      = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      failures++;
      $display("mismatch at response %0d: %s got %h want %h",
               responses_checked, what, got, want);
   endtask

   // spread over the whole key range, first and last key included
   function automatic logic [KIDX_W-1:0] pool_key(input int j);
      return KIDX_W'(j * 8 + j % 8);
   endfunction

   // commit a new mask: an empty mask falls back to the base layer
   function automatic void settle_mask(input logic [MASK_BITS-1:0] m);
      mask_model = (m == '0) ? MASK_RESET : m;
      top_model  = '0;
      for (int i = 0; i < MASK_BITS; i++)
         if (mask_model[i]) top_model = LAYER_W'(i);
   endfunction

   // flat key index at a matrix position, -1 when unmapped
   function automatic int flat_key(input logic [ROW_W-1:0] row,
                                   input logic [COL_W-1:0] col);
      logic [KIDX_W-1:0] raw;
      raw = layout_model[int'(row) * COLS_DEF + int'(col)];
      if (raw[KIDX_W-1] || int'(raw) >= KEYS_DEF) return -1;
      return int'(raw);
   endfunction

   // layers beyond the ones in use read as zero
   function automatic logic [CODE_W-1:0] layer_code(input int l, input int k);
      if (l >= LAYERS_DEF || l >= int'(liu_model)) return '0;
      return keymap_model[l * KEYS_DEF + k];
   endfunction

   // advance the predictor by one request and return the response it owes
   function automatic layer_rsp_type apply_layer_request(input layer_req_type r);
      layer_rsp_type     res;
      int                k;
      logic [CODE_W-1:0] c;
      bit                found;
      res   = '0;
      found = 1'b0;
      case (r.cmd)
         CMD_SET_MASK: begin
            settle_mask(r.mask);
            res.changed = 1'b1;
         end
         CMD_LAYER_ON: begin
            settle_mask(mask_model | (MASK_BITS'(1) << r.layer));
            res.changed = 1'b1;
         end
         CMD_LAYER_OFF: begin
            settle_mask(mask_model & ~(MASK_BITS'(1) << r.layer));
            res.changed = 1'b1;
         end
         CMD_TOGGLE: begin
            settle_mask(mask_model ^ (MASK_BITS'(1) << r.layer));
            res.changed = 1'b1;
         end
         CMD_RESOLVE: begin
            // top-down scan, skipping zero and transparent codes
            k = flat_key(r.row, r.col);
            if (k >= 0) begin
               for (int l = int'(top_model); l >= 0; l--) begin
                  if (!found && mask_model[l]) begin
                     c = layer_code(l, k);
                     if (c != '0 && c != trans_model) begin
                        res.keycode = c;
                        found       = 1'b1;
                     end
                  end
               end
            end
         end
         CMD_LOOKUP: begin
            k = flat_key(r.row, r.col);
            if (k >= 0) res.keycode = layer_code(int'(r.layer), k);
         end
         CMD_WR_KEYMAP: begin
            if (!r.key[KIDX_W-1] && int'(r.key) < KEYS_DEF)
               keymap_model[int'(r.layer) * KEYS_DEF + int'(r.key)] = r.code_in;
         end
         default: begin
            layout_model[int'(r.row) * COLS_DEF + int'(r.col)] = r.key;
         end
      endcase
      res.active = top_model;
      res.mask   = mask_model;
      return res;
   endfunction

   // keycodes biased toward zero, transparent and all ones
   function automatic logic [CODE_W-1:0] pick_keycode();
      case ($urandom_range(9))
         0, 1:    return '0;
         2, 3:    return trans_model;
         4:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // random request: every field random, then shaped per command
   // layout writes only point at pool keys or unmapped entries, so every read key is written
   function automatic layer_req_type random_layer_req();
      layer_req_type r;
      int            pick;
      r.layer   = LAYER_W'($urandom_range(15));
      r.mask    = MASK_BITS'($urandom_range(16'hFFFF));
      r.row     = ROW_W'($urandom_range(7));
      r.col     = COL_W'($urandom_range(15));
      r.key     = KIDX_W'($urandom_range(255));
      r.code_in = pick_keycode();
      pick      = $urandom_range(99);
      if (pick < 8) begin
         r.cmd = CMD_SET_MASK;
         case ($urandom_range(3))
            0:       r.mask = '0;
            1:       r.mask = MASK_BITS'(1) << $urandom_range(15);
            2:       r.mask = '1;
            default: ;
         endcase
      end else if (pick < 14) begin
         r.cmd = CMD_LAYER_ON;
      end else if (pick < 20) begin
         r.cmd = CMD_LAYER_OFF;
      end else if (pick < 28) begin
         r.cmd = CMD_TOGGLE;
      end else if (pick < 58) begin
         r.cmd = CMD_RESOLVE;
      end else if (pick < 76) begin
         r.cmd = CMD_LOOKUP;
      end else if (pick < 91) begin
         r.cmd = CMD_WR_KEYMAP;
         case ($urandom_range(3))
            0:       ;  // raw index, negative ones are dropped
            1:       r.key = KIDX_W'($urandom_range(KEYS_DEF - 1));
            default: r.key = pool_key($urandom_range(POOL_KEYS - 1));
         endcase
      end else begin
         r.cmd = CMD_WR_LAYOUT;
         if ($urandom_range(6) == 0)
            r.key = KIDX_W'(8'h80 | $urandom_range(127));
         else
            r.key = pool_key($urandom_range(POOL_KEYS - 1));
      end
      return r;
   endfunction

   // offer one request, with an optional idle gap first; predict on acceptance
   task automatic offer_request(input layer_req_type r, input bit typed,
                                input layer_rsp_type want);
      layer_rsp_type res;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.cmd;
      req_tdata  <= {5'b0, r.code_in, r.key, r.col, r.row, r.mask, r.layer};
      do @(posedge clock); while (req_tready !== 1'b1);
      res = apply_layer_request(r);
      if (r.cmd == CMD_RESOLVE && res.keycode != '0) resolve_hits++;
      expected_results.push_back(typed ? want : res);
      requests_sent++;
   endtask

   task automatic park_request();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // sender pause: let every owed response come back, then let the block settle
   task automatic wait_for_results();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == CSR_LAYERS_IN_USE)
         liu_model = value[LIU_W-1:0];
      else
         trans_model = value;
      @(posedge clock);
   endtask

   task automatic add_row(input logic [CMD_W-1:0] cmd, input int layer,
                          input logic [MASK_BITS-1:0] mask, input int row, input int col,
                          input logic [KIDX_W-1:0] key, input logic [CODE_W-1:0] code_in,
                          input bit typed, input logic [CODE_W-1:0] want_code,
                          input int want_top, input logic [MASK_BITS-1:0] want_mask,
                          input bit want_changed);
      directed_row_type d;
      d.req.cmd      = cmd;
      d.req.layer    = LAYER_W'(layer);
      d.req.mask     = mask;
      d.req.row      = ROW_W'(row);
      d.req.col      = COL_W'(col);
      d.req.key      = key;
      d.req.code_in  = code_in;
      d.typed        = typed;
      d.want.keycode = want_code;
      d.want.active  = LAYER_W'(want_top);
      d.want.mask    = want_mask;
      d.want.changed = want_changed;
      directed_rows.push_back(d);
   endtask

   task automatic check_response(input logic [55:0] d);
      layer_rsp_type got;
      layer_rsp_type want;
      got.keycode = d[31:0];
      got.active  = d[35:32];
      got.mask    = d[51:36];
      got.changed = d[52];
      responses_checked++;
      if (expected_results.size() == 0) begin
         report_mismatch("response with nothing pending, keycode", got.keycode, '0);
      end else begin
         want = expected_results.pop_front();
         if (got.keycode !== want.keycode)
            report_mismatch("keycode", got.keycode, want.keycode);
         if (got.active !== want.active)
            report_mismatch("active_layer", 32'(got.active), 32'(want.active));
         if (got.mask !== want.mask)
            report_mismatch("layer_mask", 32'(got.mask), 32'(want.mask));
         if (got.changed !== want.changed)
            report_mismatch("layer_changed", 32'(got.changed), 32'(want.changed));
      end
   endtask

   // response side: check, then pick next cycle's ready
   // a long hold-off is counted here once the sender asks for it
   int holds_served = 0;
   int hold_left    = 0;

   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready) check_response(rsp_tdata);
      if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: any handshake restarts the count
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready) ||
             (csr_valid && csr_ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("handshake watchdog expired after %0d quiet cycles", STALL_LIMIT);
      $display("tb_top failed");
      $finish;
   end

   initial begin : stimulus
      layer_rsp_type    none;
      layer_req_type    r;
      logic [LIU_W-1:0] liu_next;
      logic [31:0]      trans_next;
      none = '0;

      // predictor after reset
      mask_model  = MASK_RESET;
      top_model   = '0;
      liu_model   = LIU_RESET;
      trans_model = TRANS_RESET;
      foreach (layout_model[i]) layout_model[i] = UNMAPPED;

      // single reset pulse
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender rarely idle, receiver often
      send_idle_pct = 14;
      recv_idle_pct = 57;

      // registers at their reset values, accepted during the layout sweep
      write_csr(CSR_LAYERS_IN_USE, 32'(LIU_RESET));
      write_csr(CSR_TRANSPARENT, TRANS_RESET);

      // directed rows: cmd, layer, mask, row, col, key, code_in,
      // typed, keycode, active_layer, layer_mask, layer_changed
      // unmapped keys right after reset read nothing
      add_row(CMD_RESOLVE,   0, 16'h0000, 0, 0, 8'h00, 32'h0, 1, 32'h0,  0, 16'h0001, 0);
      add_row(CMD_LOOKUP,   15, 16'h0000, 7, 15, 8'h00, 32'h0, 1, 32'h0, 0, 16'h0001, 0);
      // empty mask falls back to the base layer
      add_row(CMD_SET_MASK,  0, 16'h0000, 0, 0, 8'h00, 32'h0, 1, 32'h0,  0, 16'h0001, 1);
      add_row(CMD_SET_MASK,  0, 16'hFFFF, 0, 0, 8'h00, 32'h0, 1, 32'h0, 15, 16'hFFFF, 1);
      add_row(CMD_LAYER_OFF, 15, 16'h0000, 0, 0, 8'h00, 32'h0, 1, 32'h0, 14, 16'h7FFF, 1);
      add_row(CMD_TOGGLE,   15, 16'h0000, 0, 0, 8'h00, 32'h0, 1, 32'h0, 15, 16'hFFFF, 1);
      add_row(CMD_SET_MASK,  0, 16'h0001, 0, 0, 8'h00, 32'h0, 1, 32'h0,  0, 16'h0001, 1);
      // turning off the last layer also falls back
      add_row(CMD_LAYER_OFF, 0, 16'h0000, 0, 0, 8'h00, 32'h0, 1, 32'h0,  0, 16'h0001, 1);
      add_row(CMD_LAYER_ON,  9, 16'h0000, 0, 0, 8'h00, 32'h0, 1, 32'h0,  9, 16'h0201, 1);
      add_row(CMD_TOGGLE,    9, 16'h0000, 0, 0, 8'h00, 32'h0, 1, 32'h0,  0, 16'h0001, 1);
      // layout corners, plus two unmapped encodings
      add_row(CMD_WR_LAYOUT, 0, 16'h0000, 0, 0, 8'h00, 32'h0, 1, 32'h0,  0, 16'h0001, 0);
      add_row(CMD_WR_LAYOUT, 0, 16'h0000, 7, 15, 8'h7F, 32'h0, 1, 32'h0, 0, 16'h0001, 0);
      add_row(CMD_WR_LAYOUT, 0, 16'h0000, 3, 5, 8'hFF, 32'h0, 1, 32'h0,  0, 16'h0001, 0);
      add_row(CMD_WR_LAYOUT, 0, 16'h0000, 3, 6, 8'h80, 32'h0, 1, 32'h0,  0, 16'h0001, 0);
      // keymap corners; layer 15 key 0 holds the transparent code
      add_row(CMD_WR_KEYMAP, 0, 16'h0000, 0, 0, 8'h00, 32'hFFFF_FFFF, 1, 32'h0,
              0, 16'h0001, 0);
      add_row(CMD_WR_KEYMAP, 15, 16'h0000, 0, 0, 8'h7F, 32'h1234_5678, 1, 32'h0,
              0, 16'h0001, 0);
      add_row(CMD_WR_KEYMAP, 0, 16'h0000, 0, 0, 8'h7F, 32'h0000_0001, 1, 32'h0,
              0, 16'h0001, 0);
      add_row(CMD_WR_KEYMAP, 15, 16'h0000, 0, 0, 8'h00, 32'h0000_0001, 1, 32'h0,
              0, 16'h0001, 0);
      // negative key index: write is dropped
      add_row(CMD_WR_KEYMAP, 3, 16'h0000, 0, 0, 8'h80, 32'hDEAD_BEEF, 1, 32'h0,
              0, 16'h0001, 0);
      add_row(CMD_RESOLVE,   0, 16'h0000, 0, 0, 8'h00, 32'h0, 1, 32'hFFFF_FFFF,
              0, 16'h0001, 0);
      // a lookup reads its layer even when that layer is not active
      add_row(CMD_LOOKUP,   15, 16'h0000, 7, 15, 8'h00, 32'h0, 1, 32'h1234_5678,
              0, 16'h0001, 0);
      // only transparent below: nothing found
      add_row(CMD_RESOLVE,   0, 16'h0000, 7, 15, 8'h00, 32'h0, 1, 32'h0, 0, 16'h0001, 0);
      add_row(CMD_SET_MASK,  0, 16'h8001, 0, 0, 8'h00, 32'h0, 1, 32'h0, 15, 16'h8001, 1);
      // top layer hit, then fall-through past a transparent entry
      add_row(CMD_RESOLVE,   0, 16'h0000, 7, 15, 8'h00, 32'h0, 0, 32'h0, 0, 16'h0, 0);
      add_row(CMD_RESOLVE,   0, 16'h0000, 0, 0, 8'h00, 32'h0, 0, 32'h0,  0, 16'h0, 0);
      add_row(CMD_RESOLVE,   0, 16'h0000, 3, 6, 8'h00, 32'h0, 1, 32'h0, 15, 16'h8001, 0);

      foreach (directed_rows[i])
         offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      // point the layout at pool keys or unmapped entries, then write those keys on every layer,
      // so no lookup ever reads an unwritten keymap entry
      r = '0;
      r.cmd = CMD_WR_LAYOUT;
      for (int p = 0; p < ROWS_DEF * COLS_DEF; p++) begin
         r.row = ROW_W'(p / COLS_DEF);
         r.col = COL_W'(p % COLS_DEF);
         if ($urandom_range(15) == 0)
            r.key = UNMAPPED;
         else
            r.key = pool_key($urandom_range(POOL_KEYS - 1));
         offer_request(r, 1'b0, none);
      end
      r.cmd = CMD_WR_KEYMAP;
      for (int p = 0; p < LAYERS_DEF * POOL_KEYS; p++) begin
         r.layer   = LAYER_W'(p / POOL_KEYS);
         r.key     = pool_key(p % POOL_KEYS);
         r.code_in = pick_keycode();
         offer_request(r, 1'b0, none);
      end

      // random phases, each under its own register setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin liu_next = 5'd16; trans_next = 32'h0000_0001; end
            1: begin liu_next = 5'd0;  trans_next = 32'h0000_0001; end
            2: begin liu_next = 5'd31; trans_next = 32'hFFFF_FFFF; end
            3: begin liu_next = 5'd1;  trans_next = 32'h0000_0000; end
            4: begin liu_next = 5'd17; trans_next = $urandom;      end
            5: begin liu_next = 5'd8;  trans_next = 32'h0000_0001; end
            6: begin liu_next = 5'd4;  trans_next = $urandom;      end
            default: begin
               liu_next   = LIU_W'($urandom_range(31));
               trans_next = $urandom;
            end
         endcase

         // idle plan: sender light first, then receiver light, then none
         if (p < 3) begin
            send_idle_pct = 14;
            recv_idle_pct = 57;
         end else if (p < 6) begin
            send_idle_pct = 57;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         // registers change only with nothing in flight
         park_request();
         wait_for_results();
         write_csr(CSR_LAYERS_IN_USE, 32'(liu_next));
         write_csr(CSR_TRANSPARENT, trans_next);
         settings_run++;

         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // long receiver hold-off while requests keep coming
            if ((p == 2 || p == 6) && i == 20) hold_requests++;
            offer_request(random_layer_req(), 1'b0, none);
         end
      end

      park_request();
      wait_for_results();
      if (expected_results.size() != 0)
         report_mismatch("responses still pending at end",
                         32'(expected_results.size()), '0);

      $display("covered %0d requests: %0d directed rows, table preload, %0d random",
               requests_sent, directed_rows.size(), RANDOM_PHASES * PHASE_ITEMS);
      $display("%0d responses checked over %0d register settings, %0d resolves found a code",
               responses_checked, settings_run + 1, resolve_hits);
      if (failures == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

/* filelist.f */
sv/klsr_pkg.sv
sv/klsr_mask_unit.sv
sv/keymap_layer_stack_resolver_top.sv
tb/sv/tb_top.sv
